[rtl/zba_pkg.sv]
// Shared types, widths and codes of the zone bitmap allocator.
package zba_pkg;

  localparam int OPCODE_W      = 1;
  localparam int WORD_INDEX_W  = 12;
  localparam int WORD_DATA_W   = 64;
  localparam int ZONE_W        = 18;
  localparam int BLOCK_W       = 32;

  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam int BLOCK_BYTES_W = 13;
  localparam int ZMAP_W        = 7;
  localparam int IMAP_W        = 8;
  localparam int ITAB_W        = 16;
  localparam int BPZ_W         = 7;
  localparam int ALIGN_W       = 11;

  // map blocks times block bytes, then times eight bits per byte
  localparam int MB_W          = ZMAP_W + BLOCK_BYTES_W;
  localparam int LIM_W         = MB_W + 3;

  // header + maps + inode table + one zone, and the aligned base
  localparam int SUM_W         = 17;
  localparam int BASE_W        = 17;
  localparam int DIV_CNT_W     = 5;

  localparam logic [OPCODE_W-1:0] OP_LOAD  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_ALLOC = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_BYTES        = 3'd0,
    CFG_ZONE_MAP_BLOCKS    = 3'd1,
    CFG_INODE_MAP_BLOCKS   = 3'd2,
    CFG_INODE_TABLE_BLOCKS = 3'd3,
    CFG_BLOCKS_PER_ZONE    = 3'd4,
    CFG_ALIGNMENT_BLOCKS   = 3'd5
  } cfg_index_t;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_INIT  = 8'b0000_0100,
    S_READ  = 8'b0000_1000,
    S_EVAL  = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  typedef struct packed {
    logic [ZMAP_W-1:0]  zone_map_blocks;
    logic [IMAP_W-1:0]  inode_map_blocks;
    logic [ITAB_W-1:0]  inode_table_blocks;
    logic [BPZ_W-1:0]   blocks_per_zone;
    logic [ALIGN_W-1:0] alignment_blocks;
  } base_cfg_t;

  typedef struct packed {
    logic              done;
    logic [BASE_W-1:0] base;
  } base_res_t;

endpackage

[rtl/zba_if.sv]
// Channel interfaces: request, response and configuration write.
interface zba_req_if;
  logic                             valid;
  logic                             ready;
  logic [zba_pkg::OPCODE_W-1:0]     opcode;
  logic [zba_pkg::WORD_INDEX_W-1:0] word_index;
  logic [zba_pkg::WORD_DATA_W-1:0]  word_data;

  modport source (output valid, opcode, word_index, word_data, input ready);
  modport sink (input valid, opcode, word_index, word_data, output ready);
endinterface

interface zba_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        ok;
  logic [zba_pkg::ZONE_W-1:0]  zone_index;
  logic [zba_pkg::BLOCK_W-1:0] block_number;

  modport source (output valid, ok, zone_index, block_number, input ready);
  modport sink (input valid, ok, zone_index, block_number, output ready);
endinterface

interface zba_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [zba_pkg::CFG_IDX_W-1:0]  index;
  logic [zba_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/zba_map_mem.sv]
// Bitmap word store: one write port, one read port, registered read data.
module zba_map_mem #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/zba_base_div.sv]
// Data region base: restoring remainder division, then round up to alignment.
module zba_base_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  zba_pkg::base_cfg_t cfg,
  output zba_pkg::base_res_t res
);

  logic                              busy;
  logic                              fin;
  logic                              done_q;
  logic [zba_pkg::BASE_W-1:0]        base_q;
  logic [zba_pkg::DIV_CNT_W-1:0]     cnt;
  logic [zba_pkg::SUM_W-1:0]         dividend;
  logic [zba_pkg::SUM_W-1:0]         sum_q;
  logic [zba_pkg::ALIGN_W-1:0]       align_q;
  logic [zba_pkg::ALIGN_W-1:0]       rem;
  logic [zba_pkg::SUM_W-1:0]         sum;
  logic [zba_pkg::ALIGN_W:0]         rem_sh;
  logic [zba_pkg::ALIGN_W:0]         rem_diff;
  logic                              rem_ge;
  logic [zba_pkg::ALIGN_W-1:0]       rem_next;

  assign sum = zba_pkg::SUM_W'(1)
             + zba_pkg::SUM_W'(cfg.inode_map_blocks)
             + zba_pkg::SUM_W'(cfg.zone_map_blocks)
             + zba_pkg::SUM_W'(cfg.inode_table_blocks)
             + zba_pkg::SUM_W'(cfg.blocks_per_zone);

  assign rem_sh   = {rem, dividend[zba_pkg::SUM_W-1]};
  assign rem_diff = rem_sh - {1'b0, align_q};
  assign rem_ge   = rem_sh >= {1'b0, align_q};
  assign rem_next = rem_ge ? zba_pkg::ALIGN_W'(rem_diff) : zba_pkg::ALIGN_W'(rem_sh);

  assign res = '{done: done_q, base: base_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      fin    <= 1'b0;
      done_q <= 1'b0;
    end else if (start) begin
      busy   <= 1'b1;
      fin    <= 1'b0;
      done_q <= 1'b0;
    end else if (busy) begin
      if (cnt == zba_pkg::DIV_CNT_W'(1)) begin
        busy <= 1'b0;
        fin  <= 1'b1;
      end
    end else if (fin) begin
      fin    <= 1'b0;
      done_q <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sum_q    <= sum;
      dividend <= sum;
      align_q  <= (cfg.alignment_blocks == '0) ? zba_pkg::ALIGN_W'(1) : cfg.alignment_blocks;
      rem      <= '0;
      cnt      <= zba_pkg::DIV_CNT_W'(zba_pkg::SUM_W);
    end else if (busy) begin
      rem      <= rem_next;
      dividend <= dividend << 1;
      cnt      <= cnt - zba_pkg::DIV_CNT_W'(1);
    end else if (fin) begin
      base_q <= (rem == '0) ? zba_pkg::BASE_W'(sum_q)
              : zba_pkg::BASE_W'(sum_q) + zba_pkg::BASE_W'(align_q - rem);
    end
  end

endmodule

[rtl/zone_bitmap_allocator_core.sv]
// Zone bitmap allocator top level: sequencer, scan datapath and config registers.
// After reset the block clears the bitmap store, one word per cycle; no request is
// taken then, configuration writes are. A load word goes from idle straight to the
// done state, which loads the response register. An allocate word reads the store
// one word at a time (read, then test and write back) from word 0 up to the first
// word with a clear bit in range; in parallel a 17-step divider works out the data
// region base, and on a full map the scan runs over every word in use. Requests
// are taken one at a time; the response register lets the next request start
// while a response still waits.
module zone_bitmap_allocator_core #(
  parameter int MAP_WORDS = 4096,
  parameter int WORD_BITS = 64
) (
  input logic       clk,
  input logic       rst,
  zba_req_if.sink   req,
  zba_rsp_if.source rsp,
  zba_cfg_if.sink   cfg
);

  localparam int AW     = $clog2(MAP_WORDS);
  localparam int CAP    = MAP_WORDS * WORD_BITS;
  localparam int ZW     = $clog2(CAP);
  localparam int RW     = ZW + 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int CMP_W  = (zba_pkg::LIM_W > RW) ? zba_pkg::LIM_W : RW;
  localparam int PW     = ZW + zba_pkg::BPZ_W;
  localparam int SW     = ((PW > zba_pkg::BASE_W) ? PW : zba_pkg::BASE_W) + 1;

  zba_pkg::state_t state;

  logic [zba_pkg::BLOCK_BYTES_W-1:0] block_bytes;
  logic [zba_pkg::ZMAP_W-1:0]        zone_map_blocks;
  logic [zba_pkg::IMAP_W-1:0]        inode_map_blocks;
  logic [zba_pkg::ITAB_W-1:0]        inode_table_blocks;
  logic [zba_pkg::BPZ_W-1:0]         blocks_per_zone;
  logic [zba_pkg::ALIGN_W-1:0]       alignment_blocks;

  logic [AW-1:0]             clr_addr;
  logic [AW-1:0]             scan_addr;
  logic [RW-1:0]             remaining;
  logic [ZW-1:0]             zone_base;
  logic [ZW-1:0]             zone_hit;
  logic [PW-1:0]             prod;
  logic                      res_ok;
  logic [zba_pkg::ZONE_W-1:0]  res_zone;
  logic [zba_pkg::BLOCK_W-1:0] res_block;

  logic                      req_accept;
  logic                      in_range;
  logic                      out_load;
  logic [zba_pkg::MB_W-1:0]  lim_mb;
  logic [zba_pkg::LIM_W-1:0] lim_raw;
  logic [RW-1:0]             lim_sat;
  logic [WORD_BITS-1:0]      lim_mask;
  logic [WORD_BITS-1:0]      free_bits;
  logic [WORD_BITS-1:0]      lowest;
  logic [BW-1:0]             bit_idx;
  logic                      found;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [WORD_BITS-1:0]      mem_wdata;
  logic                      mem_re;
  logic [WORD_BITS-1:0]      mem_rdata;

  zba_pkg::base_cfg_t        base_cfg;
  zba_pkg::base_res_t        base_res;

  assign cfg.ready  = 1'b1;
  assign req.ready  = (state == zba_pkg::S_IDLE);
  assign req_accept = req.valid && req.ready;
  assign in_range   = 32'(req.word_index) < 32'(MAP_WORDS);
  assign out_load   = (state == zba_pkg::S_DONE) && (!rsp.valid || rsp.ready);

  // bits in use, saturated at the store size
  assign lim_mb  = zba_pkg::MB_W'(zone_map_blocks) * zba_pkg::MB_W'(block_bytes);
  assign lim_raw = {lim_mb, 3'b000};
  assign lim_sat = (CMP_W'(lim_raw) > CMP_W'(CAP)) ? RW'(CAP) : RW'(lim_raw);

  assign lim_mask  = (remaining >= RW'(WORD_BITS)) ? '1
                   : ~({WORD_BITS{1'b1}} << remaining[BW-1:0]);
  assign free_bits = ~mem_rdata & lim_mask;
  assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));
  assign found     = |free_bits;

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        bit_idx = bit_idx | BW'(i);
      end
    end
  end

  assign mem_we = (state == zba_pkg::S_CLEAR)
               || (req_accept && (req.opcode == zba_pkg::OP_LOAD) && in_range)
               || ((state == zba_pkg::S_EVAL) && found);
  assign mem_waddr = (state == zba_pkg::S_CLEAR) ? clr_addr
                   : (state == zba_pkg::S_IDLE) ? AW'(req.word_index) : scan_addr;
  assign mem_wdata = (state == zba_pkg::S_CLEAR) ? '0
                   : (state == zba_pkg::S_IDLE) ? WORD_BITS'(req.word_data)
                   : (mem_rdata | lowest);
  assign mem_re    = (state == zba_pkg::S_READ) && (remaining != '0);

  assign base_cfg.zone_map_blocks    = zone_map_blocks;
  assign base_cfg.inode_map_blocks   = inode_map_blocks;
  assign base_cfg.inode_table_blocks = inode_table_blocks;
  assign base_cfg.blocks_per_zone    = blocks_per_zone;
  assign base_cfg.alignment_blocks   = alignment_blocks;

  zba_map_mem #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS)
  ) u_map_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (scan_addr),
    .rdata (mem_rdata)
  );

  zba_base_div u_base_div (
    .clk   (clk),
    .rst   (rst),
    .start (state == zba_pkg::S_INIT),
    .cfg   (base_cfg),
    .res   (base_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      block_bytes        <= zba_pkg::BLOCK_BYTES_W'(1024);
      zone_map_blocks    <= zba_pkg::ZMAP_W'(1);
      inode_map_blocks   <= zba_pkg::IMAP_W'(1);
      inode_table_blocks <= '0;
      blocks_per_zone    <= zba_pkg::BPZ_W'(1);
      alignment_blocks   <= zba_pkg::ALIGN_W'(1);
    end else if (cfg.valid && cfg.ready) begin
      unique case (zba_pkg::cfg_index_t'(cfg.index))
        zba_pkg::CFG_BLOCK_BYTES: block_bytes <= zba_pkg::BLOCK_BYTES_W'(cfg.data);
        zba_pkg::CFG_ZONE_MAP_BLOCKS: zone_map_blocks <= zba_pkg::ZMAP_W'(cfg.data);
        zba_pkg::CFG_INODE_MAP_BLOCKS: inode_map_blocks <= zba_pkg::IMAP_W'(cfg.data);
        zba_pkg::CFG_INODE_TABLE_BLOCKS: inode_table_blocks <= zba_pkg::ITAB_W'(cfg.data);
        zba_pkg::CFG_BLOCKS_PER_ZONE: blocks_per_zone <= zba_pkg::BPZ_W'(cfg.data);
        zba_pkg::CFG_ALIGNMENT_BLOCKS: alignment_blocks <= zba_pkg::ALIGN_W'(cfg.data);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= zba_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        zba_pkg::S_CLEAR: begin
          if (clr_addr == AW'(MAP_WORDS - 1)) begin
            state <= zba_pkg::S_IDLE;
          end else begin
            clr_addr <= clr_addr + AW'(1);
          end
        end
        zba_pkg::S_IDLE: begin
          if (req_accept) begin
            state <= (req.opcode == zba_pkg::OP_LOAD) ? zba_pkg::S_DONE : zba_pkg::S_INIT;
          end
        end
        zba_pkg::S_INIT: state <= zba_pkg::S_READ;
        zba_pkg::S_READ: state <= (remaining == '0) ? zba_pkg::S_DONE : zba_pkg::S_EVAL;
        zba_pkg::S_EVAL: state <= found ? zba_pkg::S_MUL : zba_pkg::S_READ;
        zba_pkg::S_MUL:  state <= zba_pkg::S_SUM;
        zba_pkg::S_SUM: begin
          if (base_res.done) begin
            state <= zba_pkg::S_DONE;
          end
        end
        zba_pkg::S_DONE: begin
          if (out_load) begin
            state <= zba_pkg::S_IDLE;
          end
        end
        default: state <= zba_pkg::S_IDLE;
      endcase
    end
  end

  // scan datapath and result word
  always_ff @(posedge clk) begin
    unique case (state)
      zba_pkg::S_IDLE: begin
        res_ok    <= in_range;
        res_zone  <= '0;
        res_block <= '0;
      end
      zba_pkg::S_INIT: begin
        remaining <= lim_sat;
        scan_addr <= '0;
        zone_base <= '0;
      end
      zba_pkg::S_READ: begin
        if (remaining == '0) begin
          res_ok    <= 1'b0;
          res_zone  <= '0;
          res_block <= '0;
        end
      end
      zba_pkg::S_EVAL: begin
        if (found) begin
          zone_hit <= zone_base + ZW'(bit_idx);
        end else begin
          remaining <= (remaining >= RW'(WORD_BITS)) ? remaining - RW'(WORD_BITS) : '0;
          scan_addr <= scan_addr + AW'(1);
          zone_base <= zone_base + ZW'(WORD_BITS);
        end
      end
      zba_pkg::S_MUL: prod <= PW'(zone_hit) * PW'(blocks_per_zone);
      zba_pkg::S_SUM: begin
        res_ok    <= 1'b1;
        res_zone  <= zba_pkg::ZONE_W'(zone_hit);
        res_block <= zba_pkg::BLOCK_W'(SW'(prod) + SW'(base_res.base));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (out_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp.ok           <= res_ok;
      rsp.zone_index   <= res_zone;
      rsp.block_number <= res_block;
    end
  end

  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && !rsp.ok |-> rsp.zone_index == '0 && rsp.block_number == '0)
    else $error("failed response carries nonzero fields");

  a_base_ready: assert property (@(posedge clk) disable iff (rst)
    state == zba_pkg::S_DONE && $past(state == zba_pkg::S_SUM) |-> $past(base_res.done))
    else $error("block number formed before base was ready");

  a_remaining_cap: assert property (@(posedge clk) disable iff (rst)
    (state == zba_pkg::S_READ || state == zba_pkg::S_EVAL) |-> remaining <= RW'(CAP))
    else $error("scan range exceeds store");

  a_read_eval: assert property (@(posedge clk) disable iff (rst)
    mem_re |=> state == zba_pkg::S_EVAL)
    else $error("read word not evaluated");

  a_one_bit: assert property (@(posedge clk) disable iff (rst)
    state == zba_pkg::S_EVAL && found |-> $countones(mem_wdata ^ mem_rdata) == 1)
    else $error("allocate write back changes other than one bit");

endmodule

[tb/tb_top.sv]
// Testbench for zone_bitmap_allocator_core: scripted and random bitmap load/allocate traffic.
`timescale 1ns / 100ps

module tb_top;

  localparam int MAP_WORDS = 4096;
  localparam int WORD_BITS = 64;
  localparam longint unsigned MAP_BITS = 64'(MAP_WORDS) * 64'(WORD_BITS);
  localparam int ITEM_TARGET = 1850;
  localparam int FILL_MAX = 48;
  localparam logic [zba_pkg::WORD_DATA_W-1:0] ONES = '1;

  typedef struct packed {
    logic                        ok;
    logic [zba_pkg::ZONE_W-1:0]  zone;
    logic [zba_pkg::BLOCK_W-1:0] block;
  } grant_t;

  typedef struct packed {
    bit                               is_cfg;
    zba_pkg::cfg_index_t              reg_sel;
    logic [zba_pkg::CFG_DATA_W-1:0]   reg_val;
    logic [zba_pkg::OPCODE_W-1:0]     op;
    logic [zba_pkg::WORD_INDEX_W-1:0] index;
    logic [zba_pkg::WORD_DATA_W-1:0]  data;
    bit                               checked;
    grant_t                           want;
  } script_row_t;

  // reset config: base 4, 8192 zones searched
  localparam script_row_t SCRIPT [30] = '{
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b1, '{1'b1, 18'd0, 32'd4}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b1, '{1'b1, 18'd1, 32'd5}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_LOAD, 12'd0,
      ONES, 1'b1, '{1'b1, 18'd0, 32'd0}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_LOAD, 12'd4095,
      64'd0, 1'b1, '{1'b1, 18'd0, 32'd0}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b1, '{1'b1, 18'd64, 32'd68}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_LOAD, 12'd1,
      64'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{1'b1, 18'd0, 32'd0}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b1, '{1'b1, 18'd127, 32'd131}},
    // nothing searched
    '{1'b1, zba_pkg::CFG_ZONE_MAP_BLOCKS, 16'd0, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b1, '{1'b0, 18'd0, 32'd0}},
    // eight zones, all in the low bits of word 0
    '{1'b1, zba_pkg::CFG_BLOCK_BYTES, 16'd1, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b1, zba_pkg::CFG_ZONE_MAP_BLOCKS, 16'd1, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b1, '{1'b0, 18'd0, 32'd0}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_LOAD, 12'd0,
      64'hFFFF_FFFF_FFFF_FF7F, 1'b1, '{1'b1, 18'd0, 32'd0}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b1, '{1'b1, 18'd7, 32'd11}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_LOAD, 12'd0,
      64'h0000_0000_0000_00FF, 1'b1, '{1'b1, 18'd0, 32'd0}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b1, '{1'b0, 18'd0, 32'd0}},
    // zero multiplier, zero alignment
    '{1'b1, zba_pkg::CFG_BLOCKS_PER_ZONE, 16'd0, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b1, zba_pkg::CFG_ALIGNMENT_BLOCKS, 16'd0, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b1, '{1'b1, 18'd0, 32'd0}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b0, '0},
    // largest base terms, then a saturated search range
    '{1'b1, zba_pkg::CFG_INODE_MAP_BLOCKS, 16'd255, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b1, zba_pkg::CFG_INODE_TABLE_BLOCKS, 16'hFFFF, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b1, zba_pkg::CFG_BLOCKS_PER_ZONE, 16'd127, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b1, zba_pkg::CFG_ALIGNMENT_BLOCKS, 16'd1024, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b1, zba_pkg::CFG_BLOCK_BYTES, 16'd8191, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b1, zba_pkg::CFG_ZONE_MAP_BLOCKS, 16'd127, zba_pkg::OP_LOAD, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b0, '0},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_LOAD, 12'd2,
      64'hA5A5_5A5A_0F0F_F0F0, 1'b1, '{1'b1, 18'd0, 32'd0}},
    '{1'b0, zba_pkg::CFG_BLOCK_BYTES, 16'd0, zba_pkg::OP_ALLOC, 12'd0,
      64'd0, 1'b0, '0}
  };

  logic clk;
  logic rst;

  zba_req_if req_ch ();
  zba_rsp_if rsp_ch ();
  zba_cfg_if cfg_ch ();

  zone_bitmap_allocator_core #(
    .MAP_WORDS (MAP_WORDS),
    .WORD_BITS (WORD_BITS)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  // shadow copy of the allocator
  logic [zba_pkg::WORD_DATA_W-1:0]   zone_map [MAP_WORDS];
  logic [zba_pkg::BLOCK_BYTES_W-1:0] block_bytes_q;
  logic [zba_pkg::ZMAP_W-1:0]        zone_map_blocks_q;
  logic [zba_pkg::IMAP_W-1:0]        inode_map_blocks_q;
  logic [zba_pkg::ITAB_W-1:0]        inode_table_blocks_q;
  logic [zba_pkg::BPZ_W-1:0]         blocks_per_zone_q;
  logic [zba_pkg::ALIGN_W-1:0]       alignment_q;

  grant_t grants_due [$];
  grant_t oldest_grant;

  int src_idle_pct;
  int stall_pct;
  int mismatches;
  int n_sent;
  int n_alloc;
  int n_full;
  int n_writes;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("tb_top: timed out with %0d words outstanding", grants_due.size());
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < 50) $display("tb_top: mismatch at %0t ns: %s", $time, what);
    mismatches++;
  endtask

  function automatic grant_t predict_grant(input logic [zba_pkg::OPCODE_W-1:0] op,
                                           input logic [zba_pkg::WORD_INDEX_W-1:0] idx,
                                           input logic [zba_pkg::WORD_DATA_W-1:0] data);
    grant_t g;
    longint unsigned limit, zone, sum, align, base;
    int w, b;
    g = '0;
    if (op == zba_pkg::OP_LOAD) begin
      zone_map[idx] = data;
      g.ok = 1'b1;
      return g;
    end
    limit = 64'(zone_map_blocks_q) * 64'(block_bytes_q) * 64'd8;
    if (limit > MAP_BITS) limit = MAP_BITS;
    for (w = 0; 64'(w) * WORD_BITS < limit; w++) begin
      if (&zone_map[w]) continue;
      for (b = 0; b < WORD_BITS; b++) begin
        zone = 64'(w) * WORD_BITS + 64'(b);
        if (zone >= limit) return g;
        if (!zone_map[w][b]) begin
          zone_map[w][b] = 1'b1;
          align = (alignment_q == '0) ? 64'd1 : 64'(alignment_q);
          sum = 64'd1 + 64'(inode_map_blocks_q) + 64'(zone_map_blocks_q)
              + 64'(inode_table_blocks_q) + 64'(blocks_per_zone_q);
          base = ((sum + align - 64'd1) / align) * align;
          g.ok = 1'b1;
          g.zone = zone[zba_pkg::ZONE_W-1:0];
          g.block = 32'(zone * 64'(blocks_per_zone_q) + base);
          return g;
        end
      end
    end
    return g;
  endfunction

  task automatic send_word(input logic [zba_pkg::OPCODE_W-1:0] op,
                           input logic [zba_pkg::WORD_INDEX_W-1:0] idx,
                           input logic [zba_pkg::WORD_DATA_W-1:0] data,
                           input bit checked, input grant_t want);
    grant_t got;
    while ($urandom_range(99) < src_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.opcode     <= op;
    req_ch.word_index <= idx;
    req_ch.word_data  <= data;
    do @(posedge clk); while (!req_ch.ready);
    got = predict_grant(op, idx, data);
    grants_due.push_back(checked ? want : got);
    n_sent++;
    if (op == zba_pkg::OP_ALLOC) begin
      n_alloc++;
      if (!got.ok) n_full++;
    end
  endtask

  task automatic drain_grants();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (grants_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input zba_pkg::cfg_index_t which,
                           input logic [zba_pkg::CFG_DATA_W-1:0] value);
    drain_grants();
    repeat (4) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= which;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (which)
      zba_pkg::CFG_BLOCK_BYTES:
        block_bytes_q        = value[zba_pkg::BLOCK_BYTES_W-1:0];
      zba_pkg::CFG_ZONE_MAP_BLOCKS:
        zone_map_blocks_q    = value[zba_pkg::ZMAP_W-1:0];
      zba_pkg::CFG_INODE_MAP_BLOCKS:
        inode_map_blocks_q   = value[zba_pkg::IMAP_W-1:0];
      zba_pkg::CFG_INODE_TABLE_BLOCKS:
        inode_table_blocks_q = value[zba_pkg::ITAB_W-1:0];
      zba_pkg::CFG_BLOCKS_PER_ZONE:
        blocks_per_zone_q    = value[zba_pkg::BPZ_W-1:0];
      zba_pkg::CFG_ALIGNMENT_BLOCKS:
        alignment_q          = value[zba_pkg::ALIGN_W-1:0];
      default: ;
    endcase
    n_writes++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (grants_due.size() == 0) begin
          flag_mismatch("response word with no request pending");
        end else begin
          oldest_grant = grants_due.pop_front();
          if (rsp_ch.ok !== oldest_grant.ok)
            flag_mismatch($sformatf("ok %b, expected %b", rsp_ch.ok, oldest_grant.ok));
          if (rsp_ch.zone_index !== oldest_grant.zone)
            flag_mismatch($sformatf("zone_index %0d, expected %0d",
                                    rsp_ch.zone_index, oldest_grant.zone));
          if (rsp_ch.block_number !== oldest_grant.block)
            flag_mismatch($sformatf("block_number %0d, expected %0d",
                                    rsp_ch.block_number, oldest_grant.block));
        end
      end
    end
  end

  initial begin
    int unsigned bb, zmb, itab, align_v;
    longint unsigned limit;
    int fill, allocs, phase, k;
    logic [zba_pkg::WORD_DATA_W-1:0] pattern;

    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.opcode <= zba_pkg::OP_LOAD;
    req_ch.word_index <= '0;
    req_ch.word_data <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= zba_pkg::CFG_BLOCK_BYTES;
    cfg_ch.data <= '0;
    for (int i = 0; i < MAP_WORDS; i++) zone_map[i] = '0;
    block_bytes_q = 13'd1024;
    zone_map_blocks_q = 7'd1;
    inode_map_blocks_q = 8'd1;
    inode_table_blocks_q = 16'd0;
    blocks_per_zone_q = 7'd1;
    alignment_q = 11'd1;
    src_idle_pct = 15;
    stall_pct = 15;
    mismatches = 0;
    n_sent = 0;
    n_alloc = 0;
    n_full = 0;
    n_writes = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (SCRIPT[r]) begin
      if (SCRIPT[r].is_cfg)
        write_reg(SCRIPT[r].reg_sel, SCRIPT[r].reg_val);
      else
        send_word(SCRIPT[r].op, SCRIPT[r].index, SCRIPT[r].data,
                  SCRIPT[r].checked, SCRIPT[r].want);
    end

    phase = 0;
    while (n_sent < ITEM_TARGET) begin
      src_idle_pct = (phase == 1 || phase == 2) ? 0 : 15;
      stall_pct = src_idle_pct;

      k = $urandom_range(9);
      if (phase == 4 || phase == 11) begin
        bb = $urandom_range(1) ? 8191 : 4096;
        zmb = $urandom_range(1) ? 127 : 64;
      end else if (k < 6) begin
        bb = $urandom_range(1, 64);
        zmb = $urandom_range(1, 6);
      end else if (k < 9) begin
        bb = $urandom_range(512, 4096);
        zmb = $urandom_range(0, 2);
      end else begin
        bb = $urandom_range(1);
        zmb = $urandom_range(3);
      end
      k = $urandom_range(3);
      itab = (k == 0) ? 65535 : (k == 1) ? 0 : $urandom_range(65535);
      k = $urandom_range(9);
      align_v = (k == 0) ? 0 : (k == 1) ? 1 : (k == 2) ? ($urandom_range(1) ? 1024 : 2047)
              : $urandom_range(1, 64);

      write_reg(zba_pkg::CFG_BLOCK_BYTES, 16'(bb));
      write_reg(zba_pkg::CFG_ZONE_MAP_BLOCKS, 16'(zmb));
      write_reg(zba_pkg::CFG_INODE_MAP_BLOCKS, 16'($urandom_range(255)));
      write_reg(zba_pkg::CFG_INODE_TABLE_BLOCKS, 16'(itab));
      write_reg(zba_pkg::CFG_BLOCKS_PER_ZONE,
                ($urandom_range(9) == 0) ? 16'd0 : 16'($urandom_range(1, 127)));
      write_reg(zba_pkg::CFG_ALIGNMENT_BLOCKS, 16'(align_v));

      limit = 64'(zone_map_blocks_q) * 64'(block_bytes_q) * 64'd8;
      if (limit > MAP_BITS) limit = MAP_BITS;
      fill = int'((limit + 63) / 64);
      if (fill > FILL_MAX) fill = FILL_MAX;

      // pack the low words nearly full so the allocations run the map dry
      for (int w = 0; w < fill; w++) begin
        if ($urandom_range(99) < 8) begin
          pattern = {$urandom, $urandom};
        end else begin
          pattern = ONES;
          repeat ($urandom_range(2)) pattern[$urandom_range(WORD_BITS - 1)] = 1'b0;
        end
        send_word(zba_pkg::OP_LOAD, zba_pkg::WORD_INDEX_W'(w), pattern, 1'b0, '0);
      end

      allocs = fill + $urandom_range(2, 8);
      for (int a = 0; a < allocs; a++) begin
        if ($urandom_range(99) == 0) drain_grants();
        if ($urandom_range(9) == 0)
          send_word(zba_pkg::OP_LOAD,
                    zba_pkg::WORD_INDEX_W'($urandom_range(MAP_WORDS - 1)),
                    {$urandom, $urandom}, 1'b0, '0);
        send_word(zba_pkg::OP_ALLOC, '0, '0, 1'b0, '0);
      end
      phase++;
    end

    drain_grants();
    repeat (50) @(posedge clk);

    $display("tb_top: %0d request words over %0d phases, %0d allocations (%0d on a full map)",
             n_sent, phase, n_alloc, n_full);
    $display("tb_top: %0d register writes, %0d mismatches", n_writes, mismatches);
    if (mismatches == 0 && grants_due.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
